@@ rtl/i64da_pkg.sv @@
// Types and constants shared by the int64 to decimal ASCII converter.
package i64da_pkg;

  localparam int VALUE_W    = 64;
  localparam int NUM_DIGITS = 20;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int DIG_CNT_W  = 5;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [7:0]                buffer_size;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       fits;
    logic [4:0] text_length;
  } out_item_t;

  // Per-cycle command shared by every digit cell.
  typedef struct packed {
    logic clear;
    logic dabble;
    logic shift_digit;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_CHECK,
    ST_ALIGN,
    ST_SIGN,
    ST_DIGITS,
    ST_TERM
  } state_t;

endpackage

@@ rtl/i64da_cell.sv @@
// One BCD digit cell: clear, shift-add-3 step, or whole-digit shift toward the top.
module i64da_cell
  import i64da_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       bit_in,
  input  logic [3:0] digit_in,
  output logic       bit_out,
  output logic [3:0] digit_out
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  assign adj       = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign bit_out   = adj[3];
  assign digit_out = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = 4'd0;
    end else if (ctrl.dabble) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctrl.shift_digit) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

@@ rtl/int64_to_decimal_ascii.sv @@
// Top level: signed 64-bit integer to decimal ASCII text, double-dabble cell chain.
//
//   channel  ports                       transfer
//   input    start, busy, in_item        start high while busy low
//   result   out_valid, out_item         out_valid high, one cycle per result
//
// The magnitude shifts through 20 BCD cells and a check state then tests the size,
// then either the error result goes out or an align state drops the leading zeros of
// n digits and one result per cycle follows (sign, digits, terminator).
// A new value is accepted only once the previous one has been fully emitted.
// Reset (rst_n low, synchronous) returns to idle and drops any pending strobe.
// The receiver cannot stall; busy falls as the last result is presented.
module int64_to_decimal_ascii
  import i64da_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  state_t                 state_r, state_nxt;
  logic [VALUE_W-1:0]     mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [7:0]             size_r, size_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [4:0]             len_r, len_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;
  cell_ctrl_t             ctrl;

  logic [3:0] dig   [NUM_DIGITS];
  logic       carry [NUM_DIGITS];
  logic [DIG_CNT_W-1:0] ndig;
  logic [4:0]           len_calc;
  logic [3:0]           top_dig;

  genvar g;
  generate
    for (g = 0; g < NUM_DIGITS; g++) begin : g_cell
      if (g == 0) begin : g_first
        i64da_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .bit_in    (mag_r[VALUE_W-1]),
          .digit_in  (4'd0),
          .bit_out   (carry[g]),
          .digit_out (dig[g])
        );
      end else begin : g_rest
        i64da_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .bit_in    (carry[g-1]),
          .digit_in  (dig[g-1]),
          .bit_out   (carry[g]),
          .digit_out (dig[g])
        );
      end
    end
  endgenerate

  assign top_dig = dig[NUM_DIGITS-1];

  // Significant digit count: highest nonzero cell, at least one digit.
  always_comb begin
    ndig = DIG_CNT_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (dig[i] != 4'd0) ndig = DIG_CNT_W'(i + 1);
    end
  end

  assign len_calc = 5'(ndig) + {4'd0, neg_r};

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    size_nxt      = size_r;
    bit_cnt_nxt   = bit_cnt_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ctrl          = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          neg_nxt     = in_item.value[VALUE_W-1];
          mag_nxt     = in_item.value[VALUE_W-1] ? (~in_item.value) + 64'd1 : in_item.value;
          size_nxt    = in_item.buffer_size;
          bit_cnt_nxt = '0;
          ctrl.clear  = 1'b1;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.dabble = 1'b1;
        mag_nxt     = {mag_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_CNT_W'(VALUE_W - 1)) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if ({3'd0, len_calc} >= size_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{character: CHAR_NUL, last: 1'b1, fits: 1'b0, text_length: 5'd0};
          state_nxt     = ST_IDLE;
        end else begin
          len_nxt   = len_calc;
          cnt_nxt   = DIG_CNT_W'(NUM_DIGITS) - ndig;
          state_nxt = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (cnt_r == '0) begin
          cnt_nxt   = DIG_CNT_W'(len_r - {4'd0, neg_r});
          state_nxt = neg_r ? ST_SIGN : ST_DIGITS;
        end else begin
          // drop one leading zero off the top
          ctrl.shift_digit = 1'b1;
          cnt_nxt          = cnt_r - 1'b1;
        end
      end
      ST_SIGN: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{character: CHAR_MINUS, last: 1'b0, fits: 1'b1, text_length: len_r};
        state_nxt     = ST_DIGITS;
      end
      ST_DIGITS: begin
        out_valid_nxt    = 1'b1;
        out_nxt          = '{character: CHAR_ZERO + {4'd0, top_dig}, last: 1'b0,
                             fits: 1'b1, text_length: len_r};
        ctrl.shift_digit = 1'b1;
        cnt_nxt          = cnt_r - 1'b1;
        if (cnt_r == DIG_CNT_W'(1)) state_nxt = ST_TERM;
      end
      ST_TERM: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{character: CHAR_NUL, last: 1'b1, fits: 1'b1, text_length: len_r};
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    size_r    <= size_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    cnt_r     <= cnt_nxt;
    len_r     <= len_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
